>>> sv/lz78_decoder_unit_defines.svh
// Assertion macros shared by the LZ78 decoder RTL.
`ifndef LZ78_DECODER_UNIT_DEFINES_SVH
`define LZ78_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define LZ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define LZ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lz78d_pkg.sv
// Shared widths, defaults and result codes of the LZ78 decoder.
package lz78d_pkg;

   localparam int IDX_W          = 12;
   localparam int BYTE_W         = 8;
   localparam int ERR_W          = 2;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 8;

   localparam int DICT_DEPTH_DEF = 4096;
   localparam int MAX_PHRASE_DEF = 64;

   localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RANGE  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_LONG   = 2'd2;
   localparam logic [ERR_W-1:0] ERR_HALTED = 2'd3;

endpackage

>>> sv/lz78d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lz78d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      // read data holds while re is low
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/lz78_decoder_unit.sv
// LZ78 token decoder: dictionary RAM, phrase stack RAM and emit sequencer.
//
//   channel | dir | tdata                              | tlast          | tuser
//   req_    | in  | phrase_index[11:0] next_byte[19:12] | last_of_stream | -
//   rsp_    | out | out_byte[7:0]                      | last_of_token  | error_code[1:0]
//
// A token with index 0 goes straight to its last byte. Otherwise the prefix walk
// reads one dictionary entry per cycle through the single dictionary read port,
// then the stack emits one byte per cycle while rsp_ accepts. Range and halted
// errors go to the error state at once, a phrase-too-long error after lookup.
// Reset is synchronous and clears only control state; the dictionary needs no
// clearing pass. A stalled rsp_ side holds the output states in place; req_tready
// is high only between tokens.
`include "lz78_decoder_unit_defines.svh"

module lz78_decoder_unit
   import lz78d_pkg::*;
#(
   parameter int DICT_DEPTH = DICT_DEPTH_DEF,
   parameter int MAX_PHRASE = MAX_PHRASE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // phrase_index, next_byte, zero pad
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_byte
   output logic                  rsp_tlast,
   output logic [ERR_W-1:0]      rsp_tuser   // error_code
);

   localparam int AW = $clog2(DICT_DEPTH);
   localparam int CW = $clog2(DICT_DEPTH + 1);
   localparam int LW = $clog2(MAX_PHRASE + 1);
   localparam int SW = $clog2(MAX_PHRASE);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOKUP = 3'd1;
   localparam logic [2:0] ST_WALK   = 3'd2;
   localparam logic [2:0] ST_PRIME  = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;
   localparam logic [2:0] ST_LAST   = 3'd5;
   localparam logic [2:0] ST_ERR    = 3'd6;

   typedef struct packed {
      logic [LW-1:0]     len;
      logic [BYTE_W-1:0] data;
      logic [IDX_W-1:0]  prefix;
   } dict_entry_type;

   localparam int DW = $bits(dict_entry_type);

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] nb_ff, nb_in;
   logic              los_ff, los_in;
   logic [LW-1:0]     plen_ff, plen_in;
   logic [LW-1:0]     walk_ff, walk_in;
   logic [SW-1:0]     pos_ff, pos_in;
   logic [ERR_W-1:0]  code_ff, code_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              error_seen_ff, error_seen_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [ERR_W-1:0]  rsp_err_ff, rsp_err_in;

   logic [IDX_W-1:0]  req_idx;
   logic [BYTE_W-1:0] req_nb;
   logic              out_free;

   logic              dict_we, dict_re;
   logic [AW-1:0]     dict_waddr, dict_raddr;
   dict_entry_type    dict_wdata, dict_rdata;
   logic [DW-1:0]     dict_rword;

   logic              stk_we, stk_re;
   logic [SW-1:0]     stk_waddr, stk_raddr;
   logic [BYTE_W-1:0] stk_wdata, stk_rdata;

   assign req_idx    = req_tdata[IDX_W-1:0];
   assign req_nb     = req_tdata[IDX_W+BYTE_W-1:IDX_W];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign dict_rdata = dict_entry_type'(dict_rword);

   lz78d_ram #(.WIDTH(DW), .DEPTH(DICT_DEPTH)) u_dict (
      .clock (clock),
      .we    (dict_we),
      .waddr (dict_waddr),
      .wdata (DW'(dict_wdata)),
      .re    (dict_re),
      .raddr (dict_raddr),
      .rdata (dict_rword)
   );

   lz78d_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PHRASE)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      nb_in         = nb_ff;
      los_in        = los_ff;
      plen_in       = plen_ff;
      walk_in       = walk_ff;
      pos_in        = pos_ff;
      code_in       = code_ff;
      count_in      = count_ff;
      error_seen_in = error_seen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;
      dict_we       = 1'b0;
      dict_waddr    = AW'(count_ff + 1'b1);
      dict_wdata    = '{len: LW'(plen_ff + 1'b1), data: nb_ff, prefix: idx_ff};
      dict_re       = 1'b0;
      dict_raddr    = AW'(req_idx);
      stk_we        = 1'b0;
      stk_waddr     = SW'(walk_ff - 1'b1);
      stk_wdata     = dict_rdata.data;
      stk_re        = 1'b0;
      stk_raddr     = SW'(pos_ff + 1'b1);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in = req_idx;
               nb_in  = req_nb;
               los_in = req_tlast;
               if (error_seen_ff) begin
                  code_in  = ERR_HALTED;
                  state_in = ST_ERR;
               end else if (req_idx == '0) begin
                  plen_in  = '0;
                  state_in = ST_LAST;
               end else if (32'(req_idx) > 32'(count_ff) || 32'(req_idx) >= DICT_DEPTH) begin
                  code_in       = ERR_RANGE;
                  error_seen_in = 1'b1;
                  state_in      = ST_ERR;
               end else begin
                  dict_re  = 1'b1;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (32'(dict_rdata.len) >= MAX_PHRASE) begin
               code_in       = ERR_LONG;
               error_seen_in = 1'b1;
               state_in      = ST_ERR;
            end else begin
               // last phrase byte goes to the top of the stack
               plen_in   = dict_rdata.len;
               stk_we    = 1'b1;
               stk_waddr = SW'(dict_rdata.len - 1'b1);
               walk_in   = dict_rdata.len - 1'b1;
               if (dict_rdata.len == LW'(1)) begin
                  state_in = ST_PRIME;
               end else begin
                  dict_re    = 1'b1;
                  dict_raddr = AW'(dict_rdata.prefix);
                  state_in   = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            stk_we  = 1'b1;
            walk_in = walk_ff - 1'b1;
            if (walk_ff == LW'(1)) begin
               state_in = ST_PRIME;
            end else begin
               dict_re    = 1'b1;
               dict_raddr = AW'(dict_rdata.prefix);
            end
         end
         ST_PRIME: begin
            // separate cycle so the first read never meets the last stack write
            stk_re    = 1'b1;
            stk_raddr = '0;
            pos_in    = '0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = stk_rdata;
               rsp_last_in  = 1'b0;
               rsp_err_in   = ERR_NONE;
               if (LW'(pos_ff) + 1'b1 < plen_ff) begin
                  stk_re = 1'b1;
                  pos_in = pos_ff + 1'b1;
               end else begin
                  state_in = ST_LAST;
               end
            end
         end
         ST_LAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = nb_ff;
               rsp_last_in  = 1'b1;
               rsp_err_in   = ERR_NONE;
               if (32'(count_ff) + 1 < DICT_DEPTH) begin
                  dict_we  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (los_ff) begin
                  count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_err_in   = code_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         error_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         error_seen_ff <= error_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      nb_ff       <= nb_in;
      los_ff      <= los_in;
      plen_ff     <= plen_in;
      walk_ff     <= walk_in;
      pos_ff      <= pos_in;
      code_ff     <= code_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   `LZ_ASSERT_NEXT(a_error_sticky, error_seen_ff, error_seen_ff, "error flag dropped without reset")
   `LZ_ASSERT_NOW(a_error_is_last, rsp_valid_ff && rsp_err_ff != ERR_NONE, rsp_last_ff, "error result without last mark")
   `LZ_ASSERT_NOW(a_no_slot_zero, dict_we, dict_waddr != '0, "dictionary write to slot 0")
   `LZ_ASSERT_NEXT(a_emit_hold, state_ff == ST_EMIT && !out_free, $stable(pos_ff) && state_ff == ST_EMIT, "stack position moved while stalled")

endmodule

>>> tb/lz78_decoder_unit_checker.sv
// Monitor, token decoder model and scoreboard for the LZ78 decoder streams.
`timescale 1ns / 100ps

module lz78_decoder_unit_checker
   import lz78d_pkg::*;
#(
   parameter int DICT_DEPTH = DICT_DEPTH_DEF,
   parameter int MAX_PHRASE = MAX_PHRASE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // phrase_index, next_byte, zero pad
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // out_byte
   input  logic                  rsp_tlast,
   input  logic [ERR_W-1:0]      rsp_tuser,  // error_code
   output int                    fail_count,
   output int                    outstanding,
   output int                    results_checked
);

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [ERR_W-1:0]  err;
   } decoded_byte_type;

   decoded_byte_type   decoded_q[$];
   logic [IDX_W-1:0]   dict_prefix[DICT_DEPTH];
   logic [BYTE_W-1:0]  dict_byte[DICT_DEPTH];
   int                 dict_len[DICT_DEPTH];
   int                 dict_count = 0;
   bit                 halted = 1'b0;
   int                 mismatches = 0;
   int                 checked = 0;

   function automatic void plan_result(input logic [BYTE_W-1:0] data, input logic last,
                                       input logic [ERR_W-1:0] err);
      decoded_byte_type r;
      r.data = data;
      r.last = last;
      r.err  = err;
      decoded_q.push_back(r);
   endfunction

   // Expected output bytes of one token, plus the dictionary update it causes.
   function automatic void decode_token(input logic [IDX_W-1:0] idx,
                                        input logic [BYTE_W-1:0] lit, input logic eos);
      logic [BYTE_W-1:0] phrase[MAX_PHRASE];
      int                ref_idx;
      int                plen;
      int                p;
      ref_idx = idx;
      plen    = 0;
      if (halted) begin
         plan_result('0, 1'b1, ERR_HALTED);
         return;
      end
      if (ref_idx != 0) begin
         if (ref_idx > dict_count || ref_idx >= DICT_DEPTH) begin
            halted = 1'b1;
            plan_result('0, 1'b1, ERR_RANGE);
            return;
         end
         plen = dict_len[ref_idx];
      end
      if (plen + 1 > MAX_PHRASE) begin
         halted = 1'b1;
         plan_result('0, 1'b1, ERR_LONG);
         return;
      end
      // prefix chain yields the phrase back to front
      p = ref_idx;
      for (int i = plen; i > 0; i--) begin
         phrase[i-1] = dict_byte[p];
         p = dict_prefix[p];
      end
      for (int i = 0; i < plen; i++)
         plan_result(phrase[i], 1'b0, ERR_NONE);
      plan_result(lit, 1'b1, ERR_NONE);
      if (dict_count + 1 < DICT_DEPTH) begin
         dict_count++;
         dict_prefix[dict_count] = idx;
         dict_byte[dict_count]   = lit;
         dict_len[dict_count]    = plen + 1;
      end
      if (eos)
         dict_count = 0;
   endfunction

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         dict_count = 0;
         halted     = 1'b0;
         decoded_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            decode_token(req_tdata[IDX_W-1:0], req_tdata[IDX_W +: BYTE_W], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (decoded_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result byte %h last %b err %0d",
                           $realtime, rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tdata !== want.data || rsp_tlast !== want.last ||
                   rsp_tuser !== want.err) begin
                  if (mismatches < 10)
                     $display("%0t: expected byte %h last %b err %0d, got byte %h last %b err %0d",
                              $realtime, want.data, want.last, want.err,
                              rsp_tdata, rsp_tlast, rsp_tuser);
                  mismatches++;
               end
            end
         end
      end
      fail_count      <= mismatches;
      outstanding     <= decoded_q.size();
      results_checked <= checked;
   end

endmodule

>>> tb/lz78_decoder_unit_tb.sv
// Stimulus, idling and verdict for the LZ78 decoder unit.
`timescale 1ns / 100ps

module lz78_decoder_unit_tb;
   import lz78d_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // phrase_index, next_byte, zero pad
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // out_byte
   logic                  rsp_tlast;
   logic [ERR_W-1:0]      rsp_tuser;       // error_code

   int fail_count;
   int outstanding;
   int results_checked;

   // stimulus-side view of the dictionary, used only to pick legal references
   int known_len[DICT_DEPTH_DEF];
   int known_count = 0;
   int sent = 0;
   bit req_calm = 1'b0;

   logic [5:0] rsp_window = '0;
   bit         rsp_calm = 1'b0;
   int         rsp_hold = 0;

   lz78_decoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   lz78_decoder_unit_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short pauses, now and then a long one
   function automatic int stall_len();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      rsp_window <= rsp_window + 1'b1;
      if (rsp_window == 0)
         rsp_calm <= ($urandom_range(0, 3) == 0);
      if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else if (!rsp_calm && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= stall_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // legal reference: 0 or a defined entry whose phrase is at most max_len bytes
   function automatic int pick_ref(input int max_len);
      int idx;
      if (known_count == 0 || $urandom_range(0, 3) == 0)
         return 0;
      idx = $urandom_range(1, known_count);
      return (known_len[idx] <= max_len) ? idx : 0;
   endfunction

   task automatic send_token(input int idx, input int lit, input int eos);
      int gap;
      int plen;
      if (sent % 32 == 0)
         req_calm = ($urandom_range(0, 3) == 0);
      gap = (req_calm || $urandom_range(0, 99) < 60) ? 0 : stall_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-IDX_W-BYTE_W){1'b0}}, BYTE_W'(lit), IDX_W'(idx)};
      req_tlast  <= (eos != 0);
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sent++;
      plen = (idx == 0) ? 0 : known_len[idx];
      if (known_count + 1 < DICT_DEPTH_DEF) begin
         known_count++;
         known_len[known_count] = plen + 1;
      end
      if (eos != 0)
         known_count = 0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int  chain_top;
      bit  range_path;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes, empty and nested prefixes, newest entry, stream end
      send_token(0, 8'h00, 1'b0);
      send_token(0, 8'hFF, 1'b0);
      send_token(1, 8'hA5, 1'b0);
      send_token(3, 8'h5A, 1'b0);
      send_token(4, 8'h01, 1'b0);
      send_token(2, 8'h80, 1'b0);
      send_token(6, 8'h7F, 1'b0);
      send_token(0, 8'h33, 1'b1);
      send_token(0, 8'hC3, 1'b0);
      send_token(1, 8'h3C, 1'b1);
      send_token(0, 8'h11, 1'b0);
      send_token(1, 8'h22, 1'b0);
      send_token(2, 8'hEE, 1'b0);

      // random well-formed tokens, occasional stream ends
      for (int n = 0; n < 40; n++) begin
         if (n == 20)
            drain();
         send_token(pick_ref(MAX_PHRASE_DEF - 1), $urandom_range(0, 255),
                    ($urandom_range(0, 19) == 0));
      end
      drain();

      // one chain up to a MAX_PHRASE-byte entry; its last token emits the longest legal output
      chain_top = 0;
      for (int n = 0; n < MAX_PHRASE_DEF; n++) begin
         send_token(chain_top, $urandom_range(0, 255), 1'b0);
         chain_top = known_count;
      end

      // a few more references, long chain entries included
      for (int n = 0; n < 4; n++)
         send_token(pick_ref(MAX_PHRASE_DEF - 1), $urandom_range(0, 255), 1'b0);
      drain();

      // the error is sticky until reset, so only one of the two kinds fits in a run
      range_path = ($urandom_range(0, 1) == 1);
      if (range_path) begin
         send_token(0, $urandom_range(0, 255), 1'b1);
         send_token($urandom_range(1, DICT_DEPTH_DEF - 1), $urandom_range(0, 255), 1'b0);
      end else begin
         send_token(chain_top, $urandom_range(0, 255), 1'b0);
      end
      for (int n = 0; n < 6; n++)
         send_token($urandom_range(0, DICT_DEPTH_DEF - 1), $urandom_range(0, 255),
                    $urandom_range(0, 1));

      drain();
      repeat (150) @(posedge clock);

      $display("%0d tokens, %0d results checked; stream ends, stalls and drains mixed in",
               sent, results_checked);
      $display("phrases up to %0d bytes; error path: %s, then halted tokens",
               MAX_PHRASE_DEF, range_path ? "index out of range" : "phrase too long");
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
